// ----- design/pts_pkg.sv -----
package pts_pkg;

  localparam int SLOTS       = 16;
  localparam int PERIOD_BITS = 32;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    KIND_FIRE = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

// ----- design/periodic_timer_slot_table_top.sv -----
// Periodic timer slot table. A request (start high while busy is low) is a tick, a slot
// start or a slot stop. Every request ends with one done result (kind 1, last 1); a tick
// from core 0 first gives one fire result per expiring slot with a non-zero id, in table
// order. Results come on valid_o for one cycle each and cannot be held off. A tick visits
// one slot per cycle through one shared phase incrementer and compare. A stop walks the
// table with the id compare up to the first match, then the later slots move up one per
// cycle. Start and all other requests go straight to their done result. busy is high from
// the request until its done result shows.
module periodic_timer_slot_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  core_i,
  input  logic [7:0]  handler_id_i,
  input  logic [31:0] interval_i,
  output logic        valid_o,
  output logic        kind_o,
  output logic [7:0]  fired_id_o,
  output logic [1:0]  status_o,
  output logic [63:0] tick_count_o,
  output logic        last_o
);

  pts_pkg::state_e state_q, state_d;

  logic [63:0]          tick_q, tick_d;
  pts_pkg::cnt_t        cnt_q, cnt_d;
  pts_pkg::idx_t        idx_q, idx_d;
  logic [7:0]           id_q, id_d;
  pts_pkg::status_e     status_q, status_d;

  logic                 valid_q, valid_d;
  pts_pkg::kind_e       kind_q, kind_d;
  logic [7:0]           fired_q, fired_d;
  pts_pkg::status_e     out_status_q, out_status_d;
  logic                 last_q, last_d;

  logic [7:0]           ident_q  [pts_pkg::SLOTS];
  pts_pkg::period_t     period_q [pts_pkg::SLOTS];
  pts_pkg::period_t     phase_q  [pts_pkg::SLOTS];

  logic                 wr_all, wr_ph;
  pts_pkg::idx_t        wr_idx;
  logic [7:0]           wr_ident;
  pts_pkg::period_t     wr_period, wr_phase;

  logic                 accept;
  pts_pkg::period_t     req_period;
  pts_pkg::idx_t        idx_nx;
  pts_pkg::period_t     ph_inc;
  logic                 ph_wrap, id_hit, idx_last, shift_last;

  assign busy       = (state_q != pts_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign req_period = pts_pkg::period_t'(interval_i);
  assign idx_nx     = pts_pkg::idx_t'(idx_q + 1'b1);

  // shared unit: phase step and compare, id compare, position checks
  assign ph_inc     = phase_q[idx_q] + 1'b1;
  assign ph_wrap    = (ph_inc >= period_q[idx_q]);
  assign id_hit     = (ident_q[idx_q] == id_q);
  assign idx_last   = (pts_pkg::cnt_t'(idx_q) == pts_pkg::cnt_t'(cnt_q - 1'b1));
  assign shift_last = (pts_pkg::cnt_t'(idx_q) == pts_pkg::cnt_t'(cnt_q - 2'd2));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (accept) begin
          state_d = pts_pkg::S_DONE;
          if (opcode_i == pts_pkg::OP_TICK && core_i == 8'd0 && cnt_q != '0) begin
            state_d = pts_pkg::S_TICK;
          end else if (opcode_i == pts_pkg::OP_STOP && cnt_q != '0) begin
            state_d = pts_pkg::S_SEARCH;
          end
        end
      end
      pts_pkg::S_TICK: begin
        if (idx_last) state_d = pts_pkg::S_DONE;
      end
      pts_pkg::S_SEARCH: begin
        if (id_hit) begin
          state_d = idx_last ? pts_pkg::S_DONE : pts_pkg::S_SHIFT;
        end else if (idx_last) begin
          state_d = pts_pkg::S_DONE;
        end
      end
      pts_pkg::S_SHIFT: begin
        if (shift_last) state_d = pts_pkg::S_DONE;
      end
      pts_pkg::S_DONE: state_d = pts_pkg::S_IDLE;
      default:         state_d = pts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    tick_d       = tick_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    id_d         = id_q;
    status_d     = status_q;
    valid_d      = 1'b0;
    kind_d       = pts_pkg::KIND_DONE;
    fired_d      = 8'd0;
    out_status_d = pts_pkg::ST_OK;
    last_d       = 1'b0;
    wr_all       = 1'b0;
    wr_ph        = 1'b0;
    wr_idx       = idx_q;
    wr_ident     = ident_q[idx_nx];
    wr_period    = period_q[idx_nx];
    wr_phase     = phase_q[idx_nx];
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (accept) begin
          idx_d    = '0;
          id_d     = handler_id_i;
          status_d = pts_pkg::ST_IGNORED;
          unique case (opcode_i)
            pts_pkg::OP_TICK: begin
              if (core_i == 8'd0) begin
                tick_d   = tick_q + 64'd1;
                status_d = pts_pkg::ST_OK;
              end
            end
            pts_pkg::OP_START: begin
              if (req_period == '0) begin
                status_d = pts_pkg::ST_IGNORED;
              end else if (cnt_q >= pts_pkg::cnt_t'(pts_pkg::SLOTS)) begin
                status_d = pts_pkg::ST_FULL;
              end else begin
                wr_all    = 1'b1;
                wr_idx    = pts_pkg::idx_t'(cnt_q);
                wr_ident  = handler_id_i;
                wr_period = req_period;
                wr_phase  = '0;
                cnt_d     = pts_pkg::cnt_t'(cnt_q + 1'b1);
                status_d  = pts_pkg::ST_OK;
              end
            end
            pts_pkg::OP_STOP: status_d = pts_pkg::ST_NOT_FOUND;
            default:          status_d = pts_pkg::ST_IGNORED;
          endcase
        end
      end
      pts_pkg::S_TICK: begin
        wr_ph    = 1'b1;
        wr_phase = ph_wrap ? '0 : ph_inc;
        if (ph_wrap && ident_q[idx_q] != 8'd0) begin
          valid_d = 1'b1;
          kind_d  = pts_pkg::KIND_FIRE;
          fired_d = ident_q[idx_q];
        end
        idx_d = idx_nx;
      end
      pts_pkg::S_SEARCH: begin
        if (id_hit) begin
          status_d = pts_pkg::ST_OK;
          if (idx_last) cnt_d = pts_pkg::cnt_t'(cnt_q - 1'b1);
        end else if (!idx_last) begin
          idx_d = idx_nx;
        end
      end
      pts_pkg::S_SHIFT: begin
        // move the next slot up into this place
        wr_all = 1'b1;
        idx_d  = idx_nx;
        if (shift_last) cnt_d = pts_pkg::cnt_t'(cnt_q - 1'b1);
      end
      pts_pkg::S_DONE: begin
        valid_d      = 1'b1;
        kind_d       = pts_pkg::KIND_DONE;
        out_status_d = status_q;
        last_d       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pts_pkg::S_IDLE;
      tick_q   <= 64'd0;
      cnt_q    <= '0;
      idx_q    <= '0;
      status_q <= pts_pkg::ST_OK;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    kind_q       <= kind_d;
    fired_q      <= fired_d;
    out_status_q <= out_status_d;
    last_q       <= last_d;
    if (wr_all) begin
      ident_q[wr_idx]  <= wr_ident;
      period_q[wr_idx] <= wr_period;
    end
    if (wr_all || wr_ph) begin
      phase_q[wr_idx] <= wr_phase;
    end
  end

  assign valid_o      = valid_q;
  assign kind_o       = kind_q;
  assign fired_id_o   = fired_q;
  assign status_o     = out_status_q;
  assign tick_count_o = tick_q;
  assign last_o       = last_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o && last_o && kind_o)
    else $error("busy dropped without a done result");

  a_fire_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !kind_o |-> fired_id_o != 8'd0 && !last_o)
    else $error("fire result with zero id or last set");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pts_pkg::cnt_t'(pts_pkg::SLOTS))
    else $error("slot count past table size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted without going busy");

endmodule
